[hw/rtl/casd_pkg.sv]
// Shared types and constants of the CAN attitude and status frame decoder.
// Has no dependencies; every other file of the block imports it.
package casd_pkg;

	// Widths of the frame fields.
	localparam int unsigned IdW   = 29;
	localparam int unsigned WordW = 16;
	localparam int unsigned TolW  = 32;
	localparam int unsigned SqW   = 31;
	localparam int unsigned SumW  = 33;
	localparam int unsigned RegIdxW = 2;

	// Squared norm of a unit quaternion in 1e-8 units.
	localparam logic [SumW-1:0] NORM_ONE = 33'd100000000;

	// Reset value of the tolerance register (0.01 in 1e-8 units).
	localparam logic [TolW-1:0] TOL_RESET = 32'd1000000;

	// Register indexes of the configuration port.
	localparam logic [RegIdxW-1:0] REG_ATT_ID = 2'd0;
	localparam logic [RegIdxW-1:0] REG_STA_ID = 2'd1;
	localparam logic [RegIdxW-1:0] REG_TOL    = 2'd2;

	// Result classification codes.
	localparam logic [1:0] KIND_ATT_OK  = 2'd0;
	localparam logic [1:0] KIND_ATT_REJ = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	// Configuration register contents.
	typedef struct packed {
		logic [IdW-1:0]  att_id;
		logic [IdW-1:0]  sta_id;
		logic [TolW-1:0] tol;
	} casd_cfg_t;

	// Load enables of the pipeline stages after the input register.
	typedef struct packed {
		logic s2;
		logic s3;
		logic res;
	} casd_adv_t;

	// Result payload that travels down the pipeline.
	typedef struct packed {
		logic [1:0]       kind;
		logic [WordW-1:0] quat_w;
		logic [WordW-1:0] quat_x;
		logic [WordW-1:0] quat_y;
		logic [WordW-1:0] quat_z;
		logic [WordW-1:0] speed;
		logic [7:0]       mode;
		logic [7:0]       shoot;
		logic [WordW-1:0] angle;
	} casd_payload_t;

endpackage

[hw/rtl/casd_cfg.sv]
// Configuration registers of the decoder: the two frame identifiers and the norm tolerance.
// Depends on casd_pkg.
module casd_cfg
	import casd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [TolW-1:0]    cfg_data,
	output casd_cfg_t          cfg
);

	casd_cfg_t cfg_q;

	// The register file can always take a transfer.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.att_id <= '0;
			cfg_q.sta_id <= '0;
			cfg_q.tol    <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATT_ID: cfg_q.att_id <= cfg_data[IdW-1:0];
				REG_STA_ID: cfg_q.sta_id <= cfg_data[IdW-1:0];
				REG_TOL:    cfg_q.tol    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/casd_norm.sv]
// Squared norm datapath: four squarers, a summing stage and the tolerance window check.
// Depends on casd_pkg.
module casd_norm
	import casd_pkg::*;
(
	input  logic             clk,
	input  casd_adv_t        adv,
	input  logic [WordW-1:0] word0,
	input  logic [WordW-1:0] word1,
	input  logic [WordW-1:0] word2,
	input  logic [WordW-1:0] word3,
	input  logic [TolW-1:0]  tol,
	output logic             within_tol
);

	logic [SqW-1:0]  sq_s2 [4];
	logic [SumW-1:0] sum_s3;
	logic [SumW-1:0] dev;

	logic signed [WordW-1:0]   comp [4];
	logic signed [2*WordW-1:0] prod [4];

	assign comp[0] = signed'(word0);
	assign comp[1] = signed'(word1);
	assign comp[2] = signed'(word2);
	assign comp[3] = signed'(word3);

	// One signed square per component; the largest, 2^30, fits in 31 bits.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = comp[i] * comp[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= prod[i][SqW-1:0];
			end
		end
	end

	// Sum of the four squares, exact in 33 bits.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= ({2'b00, sq_s2[0]} + {2'b00, sq_s2[1]})
				+ ({2'b00, sq_s2[2]} + {2'b00, sq_s2[3]});
		end
	end

	// Distance from one and the window check.
	assign dev = (sum_s3 >= NORM_ONE) ? (sum_s3 - NORM_ONE) : (NORM_ONE - sum_s3);
	assign within_tol = (dev <= {1'b0, tol});

endmodule

[hw/rtl/can_attitude_status_decoder.sv]
// Top level of the CAN attitude and status frame decoder.
// Depends on casd_pkg, casd_cfg and casd_norm.
//
// The decoder takes one CAN frame per cycle while frame_stall is low and returns exactly one
// result per frame. Each frame passes through the input register, the squarer register, the
// summing register and the result register, which presents its result. Frames follow each
// other back to back. A stall on the result side first fills any empty stages behind it; once
// all four stages hold frames, frame_stall follows result_stall in the same cycle. Attitude
// frames are classified as accepted or rejected by the squared norm window. Status frames
// update the held speed, mode bytes and angle, which every result reports as they stand after
// its own frame. Configuration writes are taken in any cycle and are meant to be made while no
// frame is in flight.
module can_attitude_status_decoder
	import casd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [TolW-1:0]    cfg_data,
	// Frame channel
	input  logic               frame_valid,
	output logic               frame_stall,
	input  logic [IdW-1:0]     frame_id,
	input  logic [WordW-1:0]   word0,
	input  logic [WordW-1:0]   word1,
	input  logic [WordW-1:0]   word2,
	input  logic [WordW-1:0]   word3,
	// Result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         frame_kind,
	output logic [WordW-1:0]   quat_w,
	output logic [WordW-1:0]   quat_x,
	output logic [WordW-1:0]   quat_y,
	output logic [WordW-1:0]   quat_z,
	output logic [WordW-1:0]   projectile_speed,
	output logic [7:0]         robot_mode,
	output logic [7:0]         shoot_select,
	output logic [WordW-1:0]   feed_angle
);

	casd_cfg_t     cfg;
	casd_adv_t     adv;
	casd_payload_t pay_next;
	casd_payload_t pay_s2;
	casd_payload_t pay_s3;
	casd_payload_t res_next;
	casd_payload_t res_q;

	logic valid_s1, valid_s2, valid_s3, res_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_res;
	logic within_tol;
	logic is_att, is_sta;

	logic [IdW-1:0]   id_s1;
	logic [WordW-1:0] w0_s1, w1_s1, w2_s1, w3_s1;

	logic [WordW-1:0] held_speed_q;
	logic [7:0]       held_mode_q;
	logic [7:0]       held_shoot_q;
	logic [WordW-1:0] held_angle_q;

	casd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage takes a new item when it is empty or its item moves on in the same cycle.
	assign rdy_res     = !res_valid_q || !result_stall;
	assign rdy_s3      = !valid_s3 || rdy_res;
	assign rdy_s2      = !valid_s2 || rdy_s3;
	assign rdy_s1      = !valid_s1 || rdy_s2;
	assign frame_stall = !rdy_s1;

	assign adv.s2  = valid_s1 && rdy_s2;
	assign adv.s3  = valid_s2 && rdy_s3;
	assign adv.res = valid_s3 && rdy_res;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= frame_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_res) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (rdy_s1 && frame_valid) begin
			id_s1 <= frame_id;
			w0_s1 <= word0;
			w1_s1 <= word1;
			w2_s1 <= word2;
			w3_s1 <= word3;
		end
	end

	// Frame decode; the attitude identifier wins when both match.
	assign is_att = (id_s1 == cfg.att_id);
	assign is_sta = !is_att && (id_s1 == cfg.sta_id);

	always_comb begin
		pay_next.kind   = is_att ? KIND_ATT_OK : (is_sta ? KIND_STATUS : KIND_IGNORED);
		pay_next.quat_x = is_att ? w0_s1 : '0;
		pay_next.quat_y = is_att ? w1_s1 : '0;
		pay_next.quat_z = is_att ? w2_s1 : '0;
		pay_next.quat_w = is_att ? w3_s1 : '0;
		pay_next.speed  = is_sta ? w0_s1 : held_speed_q;
		pay_next.mode   = is_sta ? w1_s1[15:8] : held_mode_q;
		pay_next.shoot  = is_sta ? w1_s1[7:0] : held_shoot_q;
		pay_next.angle  = is_sta ? w2_s1 : held_angle_q;
	end

	// Held status values change in frame order as each frame leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q <= '0;
			held_mode_q  <= '0;
			held_shoot_q <= '0;
			held_angle_q <= '0;
		end else if (adv.s2 && is_sta) begin
			held_speed_q <= pay_next.speed;
			held_mode_q  <= pay_next.mode;
			held_shoot_q <= pay_next.shoot;
			held_angle_q <= pay_next.angle;
		end
	end

	casd_norm u_norm (
		.clk        (clk),
		.adv        (adv),
		.word0      (w0_s1),
		.word1      (w1_s1),
		.word2      (w2_s1),
		.word3      (w3_s1),
		.tol        (cfg.tol),
		.within_tol (within_tol)
	);

	// Payload pipeline alongside the norm datapath.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			pay_s2 <= pay_next;
		end
		if (adv.s3) begin
			pay_s3 <= pay_s2;
		end
	end

	// An attitude frame outside the window is marked rejected.
	always_comb begin
		res_next = pay_s3;
		if (pay_s3.kind == KIND_ATT_OK && !within_tol) begin
			res_next.kind = KIND_ATT_REJ;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv.res) begin
			res_q <= res_next;
		end
	end

	assign result_valid     = res_valid_q;
	assign frame_kind       = res_q.kind;
	assign quat_w           = res_q.quat_w;
	assign quat_x           = res_q.quat_x;
	assign quat_y           = res_q.quat_y;
	assign quat_z           = res_q.quat_z;
	assign projectile_speed = res_q.speed;
	assign robot_mode       = res_q.mode;
	assign shoot_select     = res_q.shoot;
	assign feed_angle       = res_q.angle;

endmodule

[tb/casd_frame_checker.sv]
// Scoreboard for the CAN attitude and status frame decoder: follows the configuration,
// frame and result transfers, predicts each result and compares it field by field.
// Depends on casd_pkg.
module casd_frame_checker
	import casd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [TolW-1:0]    cfg_data,
	input  logic               frame_valid,
	input  logic               frame_stall,
	input  logic [IdW-1:0]     frame_id,
	input  logic [WordW-1:0]   word0,
	input  logic [WordW-1:0]   word1,
	input  logic [WordW-1:0]   word2,
	input  logic [WordW-1:0]   word3,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [1:0]         frame_kind,
	input  logic [WordW-1:0]   quat_w,
	input  logic [WordW-1:0]   quat_x,
	input  logic [WordW-1:0]   quat_y,
	input  logic [WordW-1:0]   quat_z,
	input  logic [WordW-1:0]   projectile_speed,
	input  logic [7:0]         robot_mode,
	input  logic [7:0]         shoot_select,
	input  logic [WordW-1:0]   feed_angle,
	output int                 mismatches,
	output int                 owed
);

	localparam longint UnitNorm2 = longint'(NORM_ONE);

	// Shadow copies of the configuration registers.
	logic [IdW-1:0]   att_id_q;
	logic [IdW-1:0]   sta_id_q;
	logic [TolW-1:0]  tol_q;

	// Status values as the decoder should be holding them.
	logic [WordW-1:0] speed_q;
	logic [7:0]       mode_q;
	logic [7:0]       shoot_q;
	logic [WordW-1:0] angle_q;

	// Results still owed by the decoder, oldest first.
	casd_payload_t    owed_results[$];
	casd_payload_t    want;

	// Prints one line per mismatch and counts it.
	task automatic report(input string msg);
		$display("%0t: ERROR %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [WordW-1:0] seen,
		input logic [WordW-1:0] expd);
		if (seen !== expd) begin
			report($sformatf("%s is %h, expected %h", name, seen, expd));
		end
	endtask

	// Square of a word read as a signed 1e-4 quaternion component.
	function automatic longint square_word(input logic [WordW-1:0] v);
		int s;
		s = $signed(v);
		return longint'(s * s);
	endfunction

	// Classifies one frame, updates the held status values and returns the result.
	function automatic casd_payload_t decode_frame(input logic [IdW-1:0] id,
		input logic [WordW-1:0] w0, w1, w2, w3);
		casd_payload_t r;
		longint n2;
		longint dev;
		r = '0;
		r.kind = KIND_IGNORED;
		if (id == att_id_q) begin
			n2 = square_word(w0) + square_word(w1) + square_word(w2) + square_word(w3);
			dev = (n2 >= UnitNorm2) ? n2 - UnitNorm2 : UnitNorm2 - n2;
			r.kind = (dev <= longint'(tol_q)) ? KIND_ATT_OK : KIND_ATT_REJ;
			r.quat_x = w0;
			r.quat_y = w1;
			r.quat_z = w2;
			r.quat_w = w3;
		end else if (id == sta_id_q) begin
			speed_q = w0;
			mode_q = w1[15:8];
			shoot_q = w1[7:0];
			angle_q = w2;
			r.kind = KIND_STATUS;
		end
		r.speed = speed_q;
		r.mode = mode_q;
		r.shoot = shoot_q;
		r.angle = angle_q;
		return r;
	endfunction

	// Follow the three channels; a result is checked before the frame of the same edge
	// is queued, so a result can never be matched to a frame taken in its own cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_id_q = '0;
			sta_id_q = '0;
			tol_q = TOL_RESET;
			speed_q = '0;
			mode_q = '0;
			shoot_q = '0;
			angle_q = '0;
			owed_results.delete();
			owed = 0;
		end else begin
			// Configuration transfers update the shadow registers.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATT_ID: att_id_q = cfg_data[IdW-1:0];
					REG_STA_ID: sta_id_q = cfg_data[IdW-1:0];
					REG_TOL:    tol_q = cfg_data;
					default:    ;
				endcase
			end
			// Each result transfer is compared with the oldest expectation.
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					report($sformatf("result of kind %0d with no frame outstanding", frame_kind));
				end else begin
					want = owed_results.pop_front();
					check_field("frame_kind", WordW'(frame_kind), WordW'(want.kind));
					check_field("quat_w", quat_w, want.quat_w);
					check_field("quat_x", quat_x, want.quat_x);
					check_field("quat_y", quat_y, want.quat_y);
					check_field("quat_z", quat_z, want.quat_z);
					check_field("projectile_speed", projectile_speed, want.speed);
					check_field("robot_mode", WordW'(robot_mode), WordW'(want.mode));
					check_field("shoot_select", WordW'(shoot_select), WordW'(want.shoot));
					check_field("feed_angle", feed_angle, want.angle);
				end
			end
			// Each frame transfer owes exactly one result.
			if (frame_valid && !frame_stall) begin
				owed_results.push_back(decode_frame(frame_id, word0, word1, word2, word3));
			end
			owed = owed_results.size();
		end
	end

endmodule

[tb/tb_can_attitude_status_decoder.sv]
// Testbench top of the CAN attitude and status frame decoder: drives configuration and frames,
// paces the result side and gives the verdict.
// Depends on casd_pkg, the decoder RTL and casd_frame_checker.
module tb_can_attitude_status_decoder;
	import casd_pkg::*;

	localparam int unsigned LimitCycles = 200000;
	localparam int          PhaseItems  = 240;
	localparam int          HoldCycles  = 300;
	localparam int          DrainCycles = 12;
	localparam logic [RegIdxW-1:0] REG_SPARE = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [RegIdxW-1:0] cfg_index;
	logic [TolW-1:0]    cfg_data;
	logic               frame_valid;
	logic               frame_stall;
	logic [IdW-1:0]     frame_id;
	logic [WordW-1:0]   word0;
	logic [WordW-1:0]   word1;
	logic [WordW-1:0]   word2;
	logic [WordW-1:0]   word3;
	logic               result_valid;
	logic               result_stall;
	logic [1:0]         frame_kind;
	logic [WordW-1:0]   quat_w;
	logic [WordW-1:0]   quat_x;
	logic [WordW-1:0]   quat_y;
	logic [WordW-1:0]   quat_z;
	logic [WordW-1:0]   projectile_speed;
	logic [7:0]         robot_mode;
	logic [7:0]         shoot_select;
	logic [WordW-1:0]   feed_angle;
	int                 mismatches;
	int                 owed;

	// Pacing of both sides, in percent of cycles.
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 holds_asked;
	int unsigned        cycle_count;

	can_attitude_status_decoder dut (.*);
	casd_frame_checker u_scoreboard (.*);

	// Free-running clock, period 4.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Hard limit on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LimitCycles) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stalls, and a long hold-off whenever one is asked for.
	initial begin
		int holds_served;
		holds_served = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				result_stall = 1'b1;
				repeat (HoldCycles) @(negedge clk);
			end
			result_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// One configuration transfer.
	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [TolW-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One frame transfer, after a random number of idle cycles.
	task automatic send_frame(input logic [IdW-1:0] id,
		input logic [WordW-1:0] a, b, c, d);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			frame_valid = 1'b0;
		end
		@(negedge clk);
		frame_valid = 1'b1;
		frame_id = id;
		word0 = a;
		word1 = b;
		word2 = c;
		word3 = d;
		do @(posedge clk); while (frame_stall);
	endtask

	// Stop offering frames and wait until every result is in and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		frame_valid = 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	initial begin
		logic [31:0]      rnd;
		logic [IdW-1:0]   att_now;
		logic [IdW-1:0]   sta_now;
		logic [TolW-1:0]  tol_now;
		logic [IdW-1:0]   fid;
		logic [WordW-1:0] wd[4];
		int               q[4];
		int               rem;
		int               k;
		int               pick;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ATT_ID;
		cfg_data = '0;
		frame_valid = 1'b0;
		frame_id = '0;
		word0 = '0;
		word1 = '0;
		word2 = '0;
		word3 = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// After reset both identifiers are zero, so the attitude reading wins.
		send_frame(29'd0, 16'd0, 16'd0, 16'd0, 16'd10000);
		send_frame(29'd5, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
		settle();

		// Extreme identifiers and an exact norm window; upper data bits are masked
		// and a write to the spare index must change nothing.
		att_now = '1;
		sta_now = '0;
		write_reg(REG_ATT_ID, 32'hFFFF_FFFF);
		write_reg(REG_STA_ID, 32'hE000_0000);
		write_reg(REG_TOL, 32'd0);
		write_reg(REG_SPARE, 32'h1234_5678);
		send_frame(att_now, 16'd0, 16'd0, 16'd0, 16'd10000);
		send_frame(att_now, 16'd1, 16'd0, 16'd0, 16'd10000);
		send_frame(att_now, 16'd0, 16'd0, 16'd0, -16'sd10000);
		send_frame(att_now, 16'd0, -16'sd10000, 16'd0, 16'd0);
		send_frame(att_now, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_frame(att_now, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_frame(att_now, 16'd0, 16'd0, 16'd0, 16'd0);
		// Status frames latch; a rejected attitude frame leaves the held values alone.
		send_frame(sta_now, 16'h8000, 16'hFF00, 16'h7FFF, 16'hFFFF);
		send_frame(att_now, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(sta_now, 16'h7FFF, 16'h00FF, 16'h8000, 16'h0000);
		send_frame(29'h0AAA_AAAA, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000);
		send_frame(29'h1555_5554, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF);
		settle();

		// Window of one unit: a deviation of one passes, four does not.
		write_reg(REG_TOL, 32'd1);
		send_frame(att_now, 16'd1, 16'd0, 16'd0, 16'd10000);
		send_frame(att_now, 16'd0, 16'd0, 16'd1, -16'sd10000);
		send_frame(att_now, 16'd2, 16'd0, 16'd0, 16'd10000);
		settle();

		// Widest window: even the largest possible norm passes.
		write_reg(REG_TOL, 32'hFFFF_FFFF);
		send_frame(att_now, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_frame(att_now, 16'd0, 16'd0, 16'd0, 16'd0);
		send_frame(sta_now, 16'h0001, 16'h0102, 16'hFFFE, 16'h1111);

		// Random phases, each with its own configuration and pacing.
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			rnd = $urandom;
			att_now = rnd[IdW-1:0];
			rnd = $urandom;
			sta_now = rnd[IdW-1:0];
			case (phase)
				0: begin
					tol_now = TOL_RESET;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					att_now = '1;
					sta_now = '0;
					tol_now = $urandom_range(2000000);
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					att_now = '0;
					sta_now = '1;
					tol_now = '0;
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				3: begin
					sta_now = att_now;
					tol_now = 32'd20000;
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
				4: begin
					tol_now = TOL_RESET;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				default: begin
					tol_now = $urandom;
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			rnd = $urandom;
			write_reg(REG_ATT_ID, {rnd[TolW-1:IdW], att_now});
			rnd = $urandom;
			write_reg(REG_STA_ID, {rnd[TolW-1:IdW], sta_now});
			write_reg(REG_TOL, tol_now);

			for (int n = 0; n < PhaseItems; n++) begin
				// Hold the result side off so the pipeline backs up into the frame input.
				if (phase == 4 && n == 20) begin
					holds_asked++;
				end
				rnd = $urandom;
				wd[0] = rnd[15:0];
				wd[1] = rnd[31:16];
				rnd = $urandom;
				wd[2] = rnd[15:0];
				wd[3] = rnd[31:16];
				rnd = $urandom;
				fid = rnd[IdW-1:0];
				pick = $urandom_range(99);
				if (pick < 45) begin
					// Attitude frame close to unit norm, one component placed at random.
					fid = att_now;
					for (int i = 0; i < 3; i++) begin
						q[i] = int'($urandom_range(11546)) - 5773;
					end
					rem = 100000000 - q[0] * q[0] - q[1] * q[1] - q[2] * q[2];
					q[3] = int'($sqrt(real'(rem)));
					case ($urandom_range(3))
						1: q[3] += int'($urandom_range(20)) - 10;
						2: q[3] += int'($urandom_range(600)) - 300;
						default: ;
					endcase
					if ($urandom_range(1) == 1) begin
						q[3] = -q[3];
					end
					k = $urandom_range(3);
					rem = q[k];
					q[k] = q[3];
					q[3] = rem;
					for (int i = 0; i < 4; i++) begin
						wd[i] = q[i][WordW-1:0];
					end
				end else if (pick < 70) begin
					fid = sta_now;
				end else if (pick < 85) begin
					fid = att_now;
				end else if (pick < 92) begin
					fid = att_now ^ (29'd1 << $urandom_range(IdW - 1));
				end
				send_frame(fid, wd[0], wd[1], wd[2], wd[3]);
			end
		end
		settle();

		if (mismatches == 0 && owed == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
